// ===== design/rpy_pkg.sv =====
`timescale 1ns / 1ps
package rpy_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 32;

    localparam int TRIG_W       = 17;
    localparam int CW           = 34;
    localparam int PHASE_W      = 32;
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int MAT_LAT      = 3;
    localparam int APPLY_LAT    = 3;
    localparam int DEPTH        = CORDIC_LAT + MAT_LAT + APPLY_LAT;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 17'sd32768;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef t_trig [8:0] t_mat;

    function automatic logic signed [CW-1:0] atan_phase(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 34'sh020000000;
            1:  v = 34'sh012E4051E;
            2:  v = 34'sh009FB385B;
            3:  v = 34'sh0051111D4;
            4:  v = 34'sh0028B0D43;
            5:  v = 34'sh00145D7E1;
            6:  v = 34'sh000A2F61E;
            7:  v = 34'sh000517C55;
            8:  v = 34'sh00028BE53;
            9:  v = 34'sh000145F2F;
            10: v = 34'sh0000A2F98;
            11: v = 34'sh0000517CC;
            12: v = 34'sh000028BE6;
            13: v = 34'sh0000145F3;
            14: v = 34'sh00000A2FA;
            15: v = 34'sh00000517D;
            16: v = 34'sh0000028BE;
            17: v = 34'sh00000145F;
            18: v = 34'sh000000A30;
            19: v = 34'sh000000518;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_trig clamp_trig(input logic signed [39:0] v);
        t_trig r;
        if (v > 40'sd32768) begin
            r = TRIG_ONE;
        end else if (v < -40'sd32768) begin
            r = -TRIG_ONE;
        end else begin
            r = TRIG_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== design/rpy_cordic.sv =====
`timescale 1ns / 1ps
module rpy_cordic #(
    parameter int ANGLE_BITS = rpy_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output rpy_pkg::t_trig        o_cos,
    output rpy_pkg::t_trig        o_sin
);
    localparam int CW = rpy_pkg::CW;
    localparam int N  = rpy_pkg::CORDIC_STEPS;

    logic [rpy_pkg::PHASE_W-1:0] phase;
    logic                        flip;
    logic signed [CW-1:0]        r_x [N+1];
    logic signed [CW-1:0]        r_y [N+1];
    logic signed [CW-1:0]        r_z [N+1];
    logic                        r_f [N+1];
    logic signed [CW-1:0]        xr, yr;
    rpy_pkg::t_trig              xc, yc;

    assign phase = {i_angle, {(rpy_pkg::PHASE_W-ANGLE_BITS){1'b0}}};
    assign flip  = phase[31] ^ phase[30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= rpy_pkg::CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= CW'($signed({phase[31] ^ flip, phase[30:0]}));
            r_f[0] <= flip;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - rpy_pkg::atan_phase(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + rpy_pkg::atan_phase(i);
                end
                r_f[i+1] <= r_f[i];
            end
        end
    end

    assign xr = (r_x[N] + 34'sd16384) >>> 15;
    assign yr = (r_y[N] + 34'sd16384) >>> 15;
    assign xc = rpy_pkg::clamp_trig(40'(xr));
    assign yc = rpy_pkg::clamp_trig(40'(yr));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_f[N] ? -xc : xc;
            o_sin <= r_f[N] ? -yc : yc;
        end
    end
endmodule

// ===== design/rpy_matrix.sv =====
`timescale 1ns / 1ps
module rpy_matrix (
    input  logic           i_clk,
    input  logic           i_en,
    input  rpy_pkg::t_trig i_cr,
    input  rpy_pkg::t_trig i_sr,
    input  rpy_pkg::t_trig i_cp,
    input  rpy_pkg::t_trig i_sp,
    input  rpy_pkg::t_trig i_cy,
    input  rpy_pkg::t_trig i_sy,
    output rpy_pkg::t_mat  o_mat
);
    rpy_pkg::t_trig        r_e00, r_e10, r_e20, r_e21, r_e22, r_cy, r_sy;
    logic signed [18:0]    r_a, r_b;
    logic signed [33:0]    r_sycr, r_sysr, r_cycr, r_cysr;
    rpy_pkg::t_trig        r2_e00, r2_e10, r2_e20, r2_e21, r2_e22;
    logic signed [36:0]    r_s01, r_s02, r_s11, r_s12;

    function automatic logic signed [18:0] rnd(input logic signed [33:0] p);
        logic signed [33:0] t;
        t = (p + 34'sd16384) >>> 15;
        return t[18:0];
    endfunction

    function automatic rpy_pkg::t_trig ent(input logic signed [36:0] s);
        logic signed [36:0] t;
        t = (s + 37'sd16384) >>> 15;
        return rpy_pkg::clamp_trig(40'(t));
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e00  <= rpy_pkg::clamp_trig(40'(rnd(i_cy * i_cp)));
            r_e10  <= rpy_pkg::clamp_trig(40'(rnd(i_sy * i_cp)));
            r_e21  <= rpy_pkg::clamp_trig(40'(rnd(i_cp * i_sr)));
            r_e22  <= rpy_pkg::clamp_trig(40'(rnd(i_cp * i_cr)));
            r_e20  <= -i_sp;
            r_a    <= rnd(i_sp * i_sr);
            r_b    <= rnd(i_sp * i_cr);
            r_sycr <= i_sy * i_cr;
            r_sysr <= i_sy * i_sr;
            r_cycr <= i_cy * i_cr;
            r_cysr <= i_cy * i_sr;
            r_cy   <= i_cy;
            r_sy   <= i_sy;

            r_s01  <= 37'(r_cy * r_a) - 37'(r_sycr);
            r_s02  <= 37'(r_cy * r_b) + 37'(r_sysr);
            r_s11  <= 37'(r_sy * r_a) + 37'(r_cycr);
            r_s12  <= 37'(r_sy * r_b) - 37'(r_cysr);
            r2_e00 <= r_e00;
            r2_e10 <= r_e10;
            r2_e20 <= r_e20;
            r2_e21 <= r_e21;
            r2_e22 <= r_e22;

            o_mat[0] <= r2_e00;
            o_mat[1] <= ent(r_s01);
            o_mat[2] <= ent(r_s02);
            o_mat[3] <= r2_e10;
            o_mat[4] <= ent(r_s11);
            o_mat[5] <= ent(r_s12);
            o_mat[6] <= r2_e20;
            o_mat[7] <= r2_e21;
            o_mat[8] <= r2_e22;
        end
    end
endmodule

// ===== design/rpy_apply.sv =====
`timescale 1ns / 1ps
module rpy_apply #(
    parameter int COORD_BITS = rpy_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_mode,
    input  rpy_pkg::t_mat                i_mat,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_z,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic signed [COORD_BITS-1:0] o_z,
    output logic                         o_sat
);
    localparam int TW   = rpy_pkg::TRIG_W;
    localparam int LO_W = COORD_BITS / 2;
    localparam int HI_W = COORD_BITS - LO_W;
    localparam int PW   = COORD_BITS + TW + 1;
    localparam int RW   = PW - 15;
    localparam int SW   = RW + 2;

    logic signed [COORD_BITS-1:0] pt [3];
    logic signed [TW+LO_W:0]      r_lo [9];
    logic signed [TW+HI_W-1:0]    r_hi [9];
    logic signed [RW-1:0]         r_rp [9];
    logic signed [SW-1:0]         sum [3];
    logic                         sat [3];

    localparam logic signed [SW-1:0] HI_LIM = SW'((64'sd1 <<< (COORD_BITS-1)) - 1);
    localparam logic signed [SW-1:0] LO_LIM = -HI_LIM - SW'(1);

    assign pt[0] = i_x;
    assign pt[1] = i_y;
    assign pt[2] = i_z;

    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            rpy_pkg::t_trig       e;
            logic signed [PW-1:0] prod;
            logic signed [PW-1:0] rsh;
            assign e    = i_mode ? i_mat[j*3+i] : i_mat[i*3+j];
            assign prod = (PW'(r_hi[i*3+j]) <<< LO_W) + PW'(r_lo[i*3+j]);
            assign rsh  = (prod + PW'(16384)) >>> 15;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lo[i*3+j] <= e * $signed({1'b0, pt[j][LO_W-1:0]});
                    r_hi[i*3+j] <= e * $signed(pt[j][COORD_BITS-1:LO_W]);
                    r_rp[i*3+j] <= rsh[RW-1:0];
                end
            end
        end
        assign sum[i] = SW'(r_rp[i*3]) + SW'(r_rp[i*3+1]) + SW'(r_rp[i*3+2]);
        assign sat[i] = (sum[i] > HI_LIM) || (sum[i] < LO_LIM);
    end

    function automatic logic signed [COORD_BITS-1:0] clip(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        t = (s > HI_LIM) ? HI_LIM : ((s < LO_LIM) ? LO_LIM : s);
        return t[COORD_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x   <= clip(sum[0]);
            o_y   <= clip(sum[1]);
            o_z   <= clip(sum[2]);
            o_sat <= sat[0] | sat[1] | sat[2];
        end
    end
endmodule

// ===== design/rpy_rotate_point.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// s_       | in        | s_tvalid / s_tready  | s_tdata: roll, pitch, yaw, x, y, z
// m_       | out       | m_tvalid / m_tready  | m_tdata: x, y, z; m_tuser: saturated
// cfg      | in        | cfg_valid / ready    | i_cfg_data: inverse_mode
//
// One word enters per cycle unless m_ stalls; words pass CORDIC, matrix, apply.
// The CORDIC, 20 iteration stages, is deepest; one word per cycle unless m_ stalls.
// Reset clears all valid bits and sets inverse_mode to 1.
// A stall at m_ freezes every stage, empty ones too; bubbles stay in place.
module rpy_rotate_point #(
    parameter int ANGLE_BITS = rpy_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = rpy_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // roll, pitch, yaw, point_x, point_y, point_z, zero pad
    input  logic [((3*ANGLE_BITS+3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // out_x, out_y, out_z, zero pad
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // saturated
    output logic [0:0] m_tuser,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);
    localparam int A      = ANGLE_BITS;
    localparam int C      = COORD_BITS;
    localparam int DEPTH  = rpy_pkg::DEPTH;
    localparam int PT_LAT = rpy_pkg::CORDIC_LAT + rpy_pkg::MAT_LAT;
    localparam int OUT_W  = ((3*C+7)/8)*8;

    logic                r_mode;
    logic [DEPTH-1:0]    r_valid;
    logic [DEPTH-1:0]    n_valid;
    logic                en;
    logic [3*C-1:0]      r_pt [PT_LAT];
    rpy_pkg::t_trig      cr, sr, cp, sp, cy, sy;
    rpy_pkg::t_mat       mat;
    logic signed [C-1:0] ox, oy, oz;
    logic                osat;

    assign en          = !r_valid[DEPTH-1] || m_tready;
    assign s_tready    = en;
    assign o_cfg_ready = 1'b1;
    assign n_valid     = {r_valid[DEPTH-2:0], s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_valid <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (en) begin
                r_valid <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt[0] <= s_tdata[3*A +: 3*C];
            for (int k = 1; k < PT_LAT; k++) begin
                r_pt[k] <= r_pt[k-1];
            end
        end
    end

    rpy_cordic #(.ANGLE_BITS(A)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_angle(s_tdata[0 +: A]), .o_cos(cr), .o_sin(sr)
    );
    rpy_cordic #(.ANGLE_BITS(A)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_angle(s_tdata[A +: A]), .o_cos(cp), .o_sin(sp)
    );
    rpy_cordic #(.ANGLE_BITS(A)) u_yaw (
        .i_clk(i_clk), .i_en(en), .i_angle(s_tdata[2*A +: A]), .o_cos(cy), .o_sin(sy)
    );

    rpy_matrix u_matrix (
        .i_clk(i_clk), .i_en(en),
        .i_cr(cr), .i_sr(sr), .i_cp(cp), .i_sp(sp), .i_cy(cy), .i_sy(sy),
        .o_mat(mat)
    );

    rpy_apply #(.COORD_BITS(C)) u_apply (
        .i_clk(i_clk), .i_en(en), .i_mode(r_mode), .i_mat(mat),
        .i_x($signed(r_pt[PT_LAT-1][0 +: C])),
        .i_y($signed(r_pt[PT_LAT-1][C +: C])),
        .i_z($signed(r_pt[PT_LAT-1][2*C +: C])),
        .o_x(ox), .o_y(oy), .o_z(oz), .o_sat(osat)
    );

    assign m_tvalid = r_valid[DEPTH-1];
    assign m_tdata  = OUT_W'({oz, oy, ox});
    assign m_tuser  = osat;

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> r_valid[0])
        else $error("accepted word not in first stage");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |=> $stable(r_valid))
        else $error("pipeline moved during stall");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && r_mode)
        else $error("reset state wrong");
endmodule
